/* rtl/core/prsc_pkg.sv */
// Shared types and codes for the paired relay switch controller.
// No dependencies; imported by prsc_step and paired_relay_switch_controller.
package prsc_pkg;

  // register bank widths (fixed by the 8-pin register layout)
  localparam int unsigned MaxPins   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned TypesW    = 16;
  localparam int unsigned PartnersW = 24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPinTypes    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPinPartners = 2'd1;

  // reset values of the configuration registers
  localparam logic [TypesW-1:0]    PinTypesRst    = 16'h0E0D;
  localparam logic [PartnersW-1:0] PinPartnersRst = 24'hFAD689;

  // item opcodes
  localparam logic [1:0] OpSwitch   = 2'd0;
  localparam logic [1:0] OpOverride = 2'd1;
  localparam logic [1:0] OpRead     = 2'd2;

  // pin roles
  localparam logic [1:0] KindSingle   = 2'd0;
  localparam logic [1:0] KindDouble   = 2'd1;
  localparam logic [1:0] KindDual     = 2'd2;
  localparam logic [1:0] KindDisabled = 2'd3;

  // override states
  localparam logic [1:0] OvrIdle = 2'd0;
  localparam logic [1:0] OvrOn   = 2'd1;
  localparam logic [1:0] OvrOff  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] pin;
    logic [1:0] value;
  } prsc_in_t;

  typedef struct packed {
    logic [7:0] output_levels;
    logic       status_changed;
    logic       store_request;
    logic       pin_level;
    logic [1:0] pin_override;
  } prsc_out_t;

endpackage

/* rtl/core/prsc_step.sv */
// Next-state and result logic for one item of the relay controller.
// Depends on prsc_pkg; instantiated by paired_relay_switch_controller.
module prsc_step #(
  parameter int unsigned ActivePins = 8
) (
  input  prsc_pkg::prsc_in_t             item_i,
  input  logic [prsc_pkg::TypesW-1:0]    pin_types_i,
  input  logic [prsc_pkg::PartnersW-1:0] pin_partners_i,
  input  logic [ActivePins-1:0]          level_i,
  input  logic [ActivePins-1:0]          prev_i,
  input  logic [ActivePins-1:0]          phase_i,
  input  logic [ActivePins-1:0][1:0]     ovr_i,
  output logic [ActivePins-1:0]          level_o,
  output logic [ActivePins-1:0]          prev_o,
  output logic [ActivePins-1:0]          phase_o,
  output logic [ActivePins-1:0][1:0]     ovr_o,
  output prsc_pkg::prsc_out_t            result_o
);
  import prsc_pkg::*;

  localparam int unsigned IdxW = $clog2(ActivePins);

  logic [ActivePins-1:0][1:0]      kind;
  logic [ActivePins-1:0][IdxW-1:0] part;
  logic [ActivePins-1:0]           rd_found;
  logic [ActivePins-1:0][IdxW-1:0] rd_to;
  logic                            pin_ok;
  logic [IdxW-1:0]                 p;

  // per-pin role and resolved partner; out-of-range partner means none
  always_comb begin
    logic [2:0] q;
    for (int i = 0; i < ActivePins; i++) begin
      kind[i] = pin_types_i[2*i +: 2];
      q       = pin_partners_i[3*i +: 3];
      part[i] = (int'(q) < ActivePins) ? q[IdxW-1:0] : IdxW'(i);
    end
  end

  // redirect target of each pin: first other pin naming it as partner
  always_comb begin
    for (int c = 0; c < ActivePins; c++) begin
      rd_found[c] = 1'b0;
      rd_to[c]    = '0;
      for (int i = ActivePins - 1; i >= 0; i--) begin
        if (i != c && part[i] == IdxW'(c)) begin
          rd_found[c] = 1'b1;
          rd_to[c]    = IdxW'(i);
        end
      end
    end
  end

  assign pin_ok = (int'(item_i.pin) < ActivePins);
  assign p      = item_i.pin[IdxW-1:0];

  // state update and result
  always_comb begin
    logic            s;
    logic            act;
    logic            chg;
    logic            st;
    logic [1:0]      k;
    logic [1:0]      ov;
    logic [1:0]      v;
    logic [IdxW-1:0] q;
    logic [IdxW-1:0] cur;
    logic            done;
    level_o = level_i;
    prev_o  = prev_i;
    phase_o = phase_i;
    ovr_o   = ovr_i;
    s       = (item_i.value != 2'd0);
    act     = 1'b0;
    chg     = 1'b0;
    st      = 1'b0;
    k       = kind[p];
    ov      = ovr_i[p];
    q       = part[p];
    v       = (item_i.value == OvrOn || item_i.value == OvrOff) ? item_i.value : OvrIdle;
    cur     = p;
    done    = 1'b0;

    if (pin_ok && item_i.opcode == OpSwitch && k != KindDisabled) begin
      // switch level: an edge cancels an override, otherwise reassert it
      if (ov != OvrIdle) begin
        if (prev_i[p] != s) begin
          ovr_o[p]  = OvrIdle;
          prev_o[p] = s;
          act       = 1'b1;
        end else if (ov == OvrOn && level_i[p]) begin
          act = 1'b0;
        end else if (ov == OvrOff && !level_i[p]) begin
          act = 1'b0;
        end else begin
          s   = (ov == OvrOn);
          act = 1'b1;
        end
      end else if (prev_i[p] != s) begin
        prev_o[p] = s;
        act       = 1'b1;
      end

      if (act) begin
        chg = 1'b1;
        case (k)
          KindSingle: begin
            st         = (level_i[p] != s);
            level_o[p] = s;
          end
          KindDouble: begin
            if (q != p) begin
              st         = (level_i[p] != s) && (level_i[q] != s);
              level_o[p] = s;
              level_o[q] = s;
              phase_o[q] = 1'b0;
            end
          end
          KindDual: begin
            if (q != p) begin
              st         = 1'b1;
              level_o[p] = s;
              level_o[q] = s && phase_i[p];
              if (!s) begin
                phase_o[p] = !phase_i[p];
              end
            end
          end
          default: begin
            st = 1'b0;
          end
        endcase
      end
    end

    // override: follow the redirect chain from disabled pins
    if (pin_ok && item_i.opcode == OpOverride) begin
      for (int hop = 0; hop <= ActivePins; hop++) begin
        if (!done) begin
          if (kind[cur] != KindDisabled) begin
            ovr_o[cur] = v;
            done       = 1'b1;
          end else if (!rd_found[cur]) begin
            done = 1'b1;
          end else begin
            cur = rd_to[cur];
          end
        end
      end
    end

    result_o.output_levels  = 8'(level_o);
    result_o.status_changed = chg;
    result_o.store_request  = st;
    result_o.pin_level      = pin_ok ? level_o[p] : 1'b0;
    result_o.pin_override   = pin_ok ? ovr_o[p] : OvrIdle;
  end

endmodule

/* rtl/core/paired_relay_switch_controller.sv */
// Paired relay switch controller: a new item may be started in every cycle and busy
// never rises. An item taken at one clock edge is evaluated in the next cycle from its
// input register, and its result sits on result_o with done_o high for the cycle after
// that. The per-pin state update is a single pass through prsc_step, which sets the
// one-item-per-cycle rate. The receiver cannot stall.
// The configuration port is always ready.
// Depends on prsc_pkg and prsc_step.
module paired_relay_switch_controller #(
  parameter int unsigned NumPins = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  prsc_pkg::prsc_in_t            item_i,
  output logic                          done_o,
  output prsc_pkg::prsc_out_t           result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [prsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [prsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import prsc_pkg::*;

  // pins beyond the 3-bit pin field are unreachable
  localparam int unsigned ActivePins = (NumPins < MaxPins) ? NumPins : MaxPins;

  logic [TypesW-1:0]          pin_types_q;
  logic [PartnersW-1:0]       pin_partners_q;
  logic [ActivePins-1:0]      level_q, level_d;
  logic [ActivePins-1:0]      prev_q, prev_d;
  logic [ActivePins-1:0]      phase_q, phase_d;
  logic [ActivePins-1:0][1:0] ovr_q, ovr_d;
  prsc_in_t                   item_q;
  logic                       item_vld_q;
  prsc_out_t                  res_d, res_q;
  logic                       done_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_types_q    <= PinTypesRst;
      pin_partners_q <= PinPartnersRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPinTypes:    pin_types_q    <= cfg_data_i[TypesW-1:0];
        CfgPinPartners: pin_partners_q <= cfg_data_i[PartnersW-1:0];
        default: begin
          pin_types_q <= pin_types_q;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q <= item_i;
    end
  end

  prsc_step #(
    .ActivePins(ActivePins)
  ) u_step (
    .item_i        (item_q),
    .pin_types_i   (pin_types_q),
    .pin_partners_i(pin_partners_q),
    .level_i       (level_q),
    .prev_i        (prev_q),
    .phase_i       (phase_q),
    .ovr_i         (ovr_q),
    .level_o       (level_d),
    .prev_o        (prev_d),
    .phase_o       (phase_d),
    .ovr_o         (ovr_d),
    .result_o      (res_d)
  );

  // pin state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      prev_q  <= '0;
      phase_q <= '0;
      ovr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= item_vld_q;
      if (item_vld_q) begin
        level_q <= level_d;
        prev_q  <= prev_d;
        phase_q <= phase_d;
        ovr_q   <= ovr_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (item_vld_q) begin
      res_q <= res_d;
    end
  end

endmodule

/* dv/paired_relay_switch_controller_test.sv */
// Self-checking testbench for paired_relay_switch_controller: drives switch, override
// and read commands under several pin role setups and checks each result transfer.
// Depends on prsc_pkg and the controller RTL; the relay state predictor lives here.
`timescale 1ns / 100ps

module paired_relay_switch_controller_test;
  import prsc_pkg::*;

  // local codes not named by the package
  localparam logic [1:0]  OpSpare          = 2'd3;
  localparam logic [1:0]  OvrBad           = 2'd3;
  localparam logic [23:0] IdentityPartners = 24'hFAC688;
  localparam logic [23:0] PairedPartners   = 24'hDE54C1;
  localparam int unsigned LatencyCycles    = 2;
  localparam int unsigned WatchdogLimit    = 1000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  prsc_in_t            item_i      = '0;
  logic                done_o;
  prsc_out_t           result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgPinTypes;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  paired_relay_switch_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predicted relay state and register copy
  logic [TypesW-1:0]    cfg_types    = PinTypesRst;
  logic [PartnersW-1:0] cfg_partners = PinPartnersRst;
  logic [7:0]           relay_level  = '0;
  logic [7:0]           switch_prev  = '0;
  logic [7:0]           toggle_phase = '0;
  logic [1:0]           ovr_state [8] = '{default: OvrIdle};

  // stimulus side bookkeeping
  logic [7:0]  switch_sent = '0;
  prsc_out_t   expected_results [$];
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;

  function automatic logic [1:0] pin_kind(logic [2:0] p);
    return cfg_types[2*p +: 2];
  endfunction

  function automatic logic [2:0] pin_partner(logic [2:0] p);
    return cfg_partners[3*p +: 3];
  endfunction

  // advance the relay state by one command and return the result it gives
  function automatic prsc_out_t step_relays(prsc_in_t it);
    prsc_out_t   res;
    logic [2:0]  p, q, cur;
    logic [1:0]  k, ov, v;
    logic        s, chg, st, stop, hit;
    int unsigned hop, i;
    p    = it.pin;
    chg  = 1'b0;
    st   = 1'b0;
    q    = p;
    if (it.opcode == OpSwitch) begin
      s    = (it.value != 2'd0);
      k    = pin_kind(p);
      ov   = ovr_state[p];
      stop = (k == KindDisabled);
      // override bookkeeping: an edge cancels it, a steady level replays it
      if (!stop) begin
        if (ov != OvrIdle) begin
          if (switch_prev[p] != s) begin
            ovr_state[p]   = OvrIdle;
            switch_prev[p] = s;
          end else if (ov == OvrOn && relay_level[p]) begin
            stop = 1'b1;
          end else if (ov == OvrOff && !relay_level[p]) begin
            stop = 1'b1;
          end else begin
            s = (ov == OvrOn);
          end
        end else if (switch_prev[p] != s) begin
          switch_prev[p] = s;
        end else begin
          stop = 1'b1;
        end
      end
      if (!stop) begin
        chg = 1'b1;
        q   = pin_partner(p);
        if (k == KindSingle) begin
          st             = (relay_level[p] != s);
          relay_level[p] = s;
        end else if (q != p) begin
          if (k == KindDouble) begin
            st              = (relay_level[p] != s) && (relay_level[q] != s);
            relay_level[p]  = s;
            relay_level[q]  = s;
            toggle_phase[q] = 1'b0;
          end else begin
            // dual toggle: on lights pin then both, off clears both and steps phase
            st = 1'b1;
            if (s) begin
              relay_level[p] = 1'b1;
              relay_level[q] = toggle_phase[p];
            end else begin
              relay_level[p]  = 1'b0;
              relay_level[q]  = 1'b0;
              toggle_phase[p] = ~toggle_phase[p];
            end
          end
        end
      end
    end else if (it.opcode == OpOverride) begin
      v    = (it.value == OvrBad) ? OvrIdle : it.value;
      cur  = p;
      stop = 1'b0;
      // a disabled pin hands the command to the first pin naming it as partner
      for (hop = 0; hop <= 8 && !stop; hop++) begin
        if (pin_kind(cur) != KindDisabled) begin
          ovr_state[cur] = v;
          stop           = 1'b1;
        end else begin
          hit = 1'b0;
          for (i = 0; i < 8 && !hit; i++) begin
            if (i[2:0] != cur && pin_partner(i[2:0]) == cur) begin
              hit = 1'b1;
              q   = i[2:0];
            end
          end
          if (hit) cur = q;
          else stop = 1'b1;
        end
      end
    end
    res.output_levels  = relay_level;
    res.status_changed = chg;
    res.store_request  = st;
    res.pin_level      = relay_level[p];
    res.pin_override   = ovr_state[p];
    return res;
  endfunction

  task automatic note_field(input string name, input int unsigned want_v,
                            input int unsigned got_v);
    if (want_v != got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // result checking, prediction on accepted transfers, register tracking, watchdog
  always @(posedge clk_i) begin : monitor
    prsc_out_t want;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, expected none actual %h",
                   $time, result_o);
        end else begin
          want = expected_results.pop_front();
          note_field("output_levels", want.output_levels, result_o.output_levels);
          note_field("status_changed", want.status_changed, result_o.status_changed);
          note_field("store_request", want.store_request, result_o.store_request);
          note_field("pin_level", want.pin_level, result_o.pin_level);
          note_field("pin_override", want.pin_override, result_o.pin_override);
          results_checked++;
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        expected_results.push_back(step_relays(item_i));
        items_sent++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        reg_writes++;
        if (cfg_index_i == CfgPinTypes) cfg_types = cfg_data_i[TypesW-1:0];
        else if (cfg_index_i == CfgPinPartners) cfg_partners = cfg_data_i[PartnersW-1:0];
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, WatchdogLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one command transfer; start stays high for a following command
  task automatic send_item(input prsc_in_t it);
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // both registers in back-to-back transfers while the block is idle
  task automatic write_config(input logic [TypesW-1:0] types,
                              input logic [PartnersW-1:0] partners);
    drain_results();
    cfg_index_i <= CfgPinTypes;
    cfg_data_i  <= CfgDataW'(types);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgPinPartners;
    cfg_data_i  <= CfgDataW'(partners);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic prsc_in_t make_item(logic [1:0] op, logic [2:0] p, logic [1:0] v);
    prsc_in_t it;
    it.opcode = op;
    it.pin    = p;
    it.value  = v;
    return it;
  endfunction

  // mostly switch edges, some steady levels, overrides and reads
  function automatic prsc_in_t pick_item();
    int unsigned r;
    logic [2:0]  p;
    logic        lvl;
    r = $urandom_range(0, 99);
    p = 3'($urandom_range(0, 7));
    if (r < 55) begin
      lvl            = switch_sent[p] ^ ($urandom_range(0, 3) != 0);
      switch_sent[p] = lvl;
      return make_item(OpSwitch, p, lvl ? 2'($urandom_range(1, 3)) : 2'd0);
    end else if (r < 80) begin
      return make_item(OpOverride, p,
                       ($urandom_range(0, 9) == 0) ? OvrBad : 2'($urandom_range(0, 2)));
    end else if (r < 95) begin
      return make_item(OpRead, p, 2'($urandom_range(0, 3)));
    end
    return make_item(OpSpare, p, 2'($urandom_range(0, 3)));
  endfunction

  function automatic prsc_in_t switch_toggle(logic [2:0] p);
    switch_sent[p] = ~switch_sent[p];
    return make_item(OpSwitch, p, switch_sent[p] ? 2'($urandom_range(1, 3)) : 2'd0);
  endfunction

  // bursts of random length separated by random gaps, some bursts back to back
  task automatic run_bursts(input int unsigned count);
    int unsigned sent, burst, gap, j;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (j = 0; j < burst && sent < count; j++) begin
        send_item(pick_item());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) idle_for(gap);
    end
  endtask

  // reset roles: double pin with disabled partner, singles, dual pair
  task automatic test_directed();
    send_item(make_item(OpRead, 3'd0, 2'd0));
    send_item(make_item(OpRead, 3'd7, 2'd3));
    send_item(make_item(OpSwitch, 3'd0, 2'd1));
    send_item(make_item(OpSwitch, 3'd0, 2'd0));
    send_item(make_item(OpSwitch, 3'd1, 2'd1));
    send_item(make_item(OpOverride, 3'd1, OvrOn));
    send_item(make_item(OpSwitch, 3'd0, 2'd0));
    send_item(make_item(OpSwitch, 3'd0, 2'd0));
    send_item(make_item(OpSwitch, 3'd0, 2'd2));
    send_item(make_item(OpOverride, 3'd2, OvrBad));
    send_item(make_item(OpOverride, 3'd2, OvrOff));
    send_item(make_item(OpSwitch, 3'd2, 2'd0));
    send_item(make_item(OpSwitch, 3'd2, 2'd3));
    send_item(make_item(OpSwitch, 3'd4, 2'd1));
    send_item(make_item(OpSwitch, 3'd4, 2'd0));
    send_item(make_item(OpSwitch, 3'd4, 2'd1));
    send_item(make_item(OpSwitch, 3'd4, 2'd0));
    send_item(make_item(OpOverride, 3'd5, OvrOn));
    send_item(make_item(OpSpare, 3'd3, 2'd3));
    send_item(make_item(OpOverride, 3'd7, OvrOn));
    send_item(make_item(OpSwitch, 3'd7, 2'd0));
    send_item(make_item(OpOverride, 3'd7, OvrOff));
    send_item(make_item(OpSwitch, 3'd7, 2'd0));
    send_item(make_item(OpRead, 3'd6, 2'd3));
    switch_sent = 8'b0000_0101;
  endtask

  // register extremes, roles without partners and fully disabled chains
  task automatic test_config_extremes();
    logic [TypesW-1:0]    types [5];
    logic [PartnersW-1:0] partners [5];
    int unsigned          c, j;
    types    = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555};
    partners = '{24'h000000, 24'hFFFFFF, IdentityPartners, IdentityPartners,
                 PairedPartners};
    for (c = 0; c < 5; c++) begin
      write_config(types[c], partners[c]);
      for (j = 0; j < 12; j++) send_item(pick_item());
    end
  endtask

  // all pins dual toggle in pairs, well-formed on and off sequences
  task automatic test_dual_toggle();
    int unsigned j;
    write_config(16'hAAAA, PairedPartners);
    for (j = 0; j < 60; j++) begin
      if ($urandom_range(0, 4) == 0) send_item(pick_item());
      else send_item(switch_toggle(3'($urandom_range(0, 7))));
      if ($urandom_range(0, 5) == 0) idle_for($urandom_range(1, 3));
    end
  endtask

  // random role and partner maps, with a full pause partway through one setup
  task automatic test_random_configs();
    logic [TypesW-1:0]    types;
    logic [PartnersW-1:0] partners;
    int unsigned          c, p, r;
    for (c = 0; c < 5; c++) begin
      if ($urandom_range(0, 3) == 0) begin
        types = TypesW'($urandom_range(0, 16'hFFFF));
      end else begin
        for (p = 0; p < 8; p++) begin
          r = $urandom_range(0, 9);
          types[2*p +: 2] = (r < 3) ? KindSingle : (r < 6) ? KindDouble :
                            (r < 9) ? KindDual : KindDisabled;
        end
      end
      r = $urandom_range(0, 2);
      partners = (r == 0) ? PairedPartners :
                 (r == 1) ? PartnersW'($urandom_range(0, 24'hFFFFFF)) :
                 (PairedPartners ^ PartnersW'($urandom_range(0, 24'hFFFFFF) &
                                               24'h249249));
      write_config(types, partners);
      if (c == 2) begin
        run_bursts(115);
        drain_results();
        run_bursts(115);
      end else begin
        run_bursts(230);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_dual_toggle();
    test_random_configs();
    drain_results();
    repeat (LatencyCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0t: %0d results never arrived, expected %0d actual 0",
               $time, expected_results.size(), expected_results.size());
    end
    $display("run covered %0d commands over %0d register transfers, %0d results checked",
             items_sent, reg_writes, results_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
